>>> src/tfc_pkg.sv
// Shared types, constants and header layout for the transport frame checker.
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

    localparam int HEADER_BYTES_DEF = 12;
    localparam logic [3:0] IF_SENTINEL = 4'd8;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    localparam int CAP_W = 16;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd1600;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ENABLE = 2'd1;

    // header byte offsets
    localparam int HDR_IFACE  = 0;
    localparam int HDR_FLAGS  = 1;
    localparam int HDR_LEN_LO = 2;
    localparam int HDR_LEN_HI = 3;
    localparam int HDR_OFF_LO = 4;
    localparam int HDR_OFF_HI = 5;
    localparam int HDR_SUM_LO = 6;
    localparam int HDR_SUM_HI = 7;
    localparam int HDR_RSVD0  = 8;
    localparam int HDR_RSVD1  = 9;
    localparam int HDR_FLOW   = 10;
    localparam int HDR_RSVD2  = 11;

    localparam logic [7:0] NIBBLE_MASK    = 8'h0f;
    localparam logic [7:0] FLOW_MASK      = 8'h03;
    localparam logic [7:0] SENTINEL_TOP   = 8'hf0;
    localparam logic [7:0] FLOW_RSVD_MASK = 8'hfc;

    localparam logic [1:0] FLOW_SET   = 2'd1;
    localparam logic [1:0] FLOW_CLEAR = 2'd2;

    localparam logic [2:0] VD_DELIVERED = 3'd0;
    localparam logic [2:0] VD_FLOW_OK   = 3'd1;
    localparam logic [2:0] VD_SHORT     = 3'd2;
    localparam logic [2:0] VD_BAD_SENT  = 3'd3;
    localparam logic [2:0] VD_BAD_HDR   = 3'd4;
    localparam logic [2:0] VD_BAD_CSUM  = 3'd5;
    localparam logic [2:0] VD_EMPTY     = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [3:0] channel;
        logic [7:0] flags;
        logic [2:0] verdict;
        logic       throttled;
        logic       released;
        logic       last;
    } result_t;

    // up to two results produced by one byte, first in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } results_t;

endpackage

`default_nettype wire

>>> src/transport_frame_checker.sv
// Top level: byte stream in, payload bytes and frame verdicts out.
// An accepted byte is first registered at the input, then its results are written into the output queue.
// Throughput: one byte per cycle while the result queue has room for two results; a final
// byte that is also payload yields two results, which leave the four-entry queue one at a time.
// Reset (rst_n low, asynchronous) clears position, sum, throttle and queue, and sets
// frame_capacity to 1600 and checksum_enable to 1; header bytes are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module transport_frame_checker #(
    parameter int HEADER_BYTES = tfc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // rx_byte
    input  wire logic                          s_axis_tlast,  // end_of_frame
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // payload_byte[7:0], channel[11:8], frame_flags[19:12], verdict[22:20],
    // throttled[23], throttle_released[24], zero[31:25]
    output logic [31:0]                        m_axis_tdata,
    output logic                               m_axis_tuser,  // result_kind
    output logic                               m_axis_tlast,  // run_last
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import tfc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       advance;
    logic       room;
    results_t   results;
    result_t    out_item;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // hold the input request until the queue has space for two results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eof_reg  <= s_axis_tlast;
        end
    end

    tfc_frame_core #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(advance),
        .item_byte (in_byte_reg),
        .item_eof  (in_eof_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .results   (results)
    );

    tfc_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (results),
        .room     (room),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_item (out_item)
    );

    assign m_axis_tdata = {7'h00, out_item.released, out_item.throttled, out_item.verdict,
                           out_item.flags, out_item.channel, out_item.payload};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

>>> src/tfc_frame_core.sv
// Frame state, header capture, byte sum and verdict logic for one byte.
`timescale 1ns / 1ps
`default_nettype none

module tfc_frame_core #(
    parameter int HEADER_BYTES = tfc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire logic [7:0]                   item_byte,
    input  wire logic                         item_eof,
    input  wire logic                         cfg_we,
    input  wire logic [tfc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [15:0]                  cfg_wdata,
    output tfc_pkg::results_t                 results
);
    import tfc_pkg::*;

    localparam int IDX_W = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] HB_POS = POS_W'(HEADER_BYTES);
    localparam logic [CAP_W-1:0] HB_CAP = CAP_W'(HEADER_BYTES);
    localparam logic [15:0] HB_16 = 16'(HEADER_BYTES);

    logic [7:0]       hdr_reg [HEADER_BYTES];
    logic [7:0]       hdr_cur [HEADER_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic             throttle_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic             csum_en_reg;

    logic [IDX_W-1:0] wr_idx;
    logic             in_header;
    logic             is_payload;
    logic             add_byte;
    logic [POS_W-1:0] payload_end;
    logic [POS_W-1:0] count;
    logic             short_frame;
    logic [15:0]      length, offset, csum_field;
    logic [1:0]       flow;
    logic [CAP_W-1:0] limit;
    logic [POS_W-1:0] span;
    logic             sentinel, sentinel_bad, header_bad;
    logic             throttle_new, apply_flow;
    logic [2:0]       verdict;
    result_t          pay_res, vd_res;

    assign wr_idx    = pos_reg[IDX_W-1:0];
    assign in_header = pos_reg < HB_POS;

    always_comb
    begin
        hdr_cur = hdr_reg;
        if (in_header)
        begin
            hdr_cur[wr_idx] = item_byte;
        end
    end

    assign payload_end = HB_POS + {1'b0, hdr_reg[HDR_LEN_HI], hdr_reg[HDR_LEN_LO]};
    assign is_payload  = !in_header && (pos_reg < payload_end);
    assign add_byte    = (in_header && pos_reg != POS_W'(HDR_SUM_LO)
                          && pos_reg != POS_W'(HDR_SUM_HI)) || is_payload;
    assign sum_next    = add_byte ? sum_reg + {8'h00, item_byte} : sum_reg;
    assign count       = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : POS_MAX;
    assign short_frame = count < HB_POS;

    assign length     = {hdr_cur[HDR_LEN_HI], hdr_cur[HDR_LEN_LO]};
    assign offset     = {hdr_cur[HDR_OFF_HI], hdr_cur[HDR_OFF_LO]};
    assign csum_field = {hdr_cur[HDR_SUM_HI], hdr_cur[HDR_SUM_LO]};
    assign flow       = hdr_cur[HDR_FLOW][1:0] & FLOW_MASK[1:0];

    assign limit = (capacity_reg < HB_CAP) ? '0 : capacity_reg - HB_CAP;
    assign span  = {1'b0, offset} + {1'b0, length};

    assign sentinel = (length == 16'd0)
                      && ((hdr_cur[HDR_IFACE] & NIBBLE_MASK) == {4'h0, IF_SENTINEL});
    assign sentinel_bad = (hdr_cur[HDR_IFACE] != (SENTINEL_TOP | {4'h0, IF_SENTINEL}))
                          || (hdr_cur[HDR_FLAGS] != 8'h00) || (offset != 16'd0)
                          || (csum_field != 16'd0) || (hdr_cur[HDR_RSVD0] != 8'h00)
                          || (hdr_cur[HDR_RSVD1] != 8'h00)
                          || ((hdr_cur[HDR_FLOW] & FLOW_RSVD_MASK) != 8'h00)
                          || (hdr_cur[HDR_RSVD2] != 8'h00);
    assign header_bad = (offset != HB_16) || (length > limit) || (span > count);

    always_comb
    begin
        case (flow)
            FLOW_SET:   throttle_new = 1'b1;
            FLOW_CLEAR: throttle_new = 1'b0;
            default:    throttle_new = throttle_reg;
        endcase
    end

    always_comb
    begin
        apply_flow = 1'b0;
        if (short_frame)
        begin
            verdict = VD_SHORT;
        end
        else if (sentinel)
        begin
            apply_flow = !sentinel_bad;
            verdict    = sentinel_bad ? VD_BAD_SENT : VD_FLOW_OK;
        end
        else if (header_bad)
        begin
            verdict = VD_BAD_HDR;
        end
        else if (csum_en_reg && (sum_next != csum_field))
        begin
            verdict = VD_BAD_CSUM;
        end
        else
        begin
            apply_flow = 1'b1;
            if (length != 16'd0)
                verdict = VD_DELIVERED;
            else if (flow == FLOW_SET || flow == FLOW_CLEAR)
                verdict = VD_FLOW_OK;
            else
                verdict = VD_EMPTY;
        end
    end

    always_comb
    begin
        pay_res.kind      = KIND_PAYLOAD;
        pay_res.payload   = item_byte;
        pay_res.channel   = hdr_reg[HDR_IFACE][3:0];
        pay_res.flags     = hdr_reg[HDR_FLAGS];
        pay_res.verdict   = VD_DELIVERED;
        pay_res.throttled = throttle_reg;
        pay_res.released  = 1'b0;
        pay_res.last      = !item_eof;

        vd_res.kind      = KIND_VERDICT;
        vd_res.payload   = 8'h00;
        vd_res.channel   = short_frame ? 4'h0 : hdr_cur[HDR_IFACE][3:0];
        vd_res.flags     = short_frame ? 8'h00 : hdr_cur[HDR_FLAGS];
        vd_res.verdict   = verdict;
        vd_res.throttled = apply_flow ? throttle_new : throttle_reg;
        vd_res.released  = apply_flow && throttle_reg && !throttle_new;
        vd_res.last      = 1'b1;

        if (!item_valid)
        begin
            results.count  = 2'd0;
            results.first  = pay_res;
            results.second = vd_res;
        end
        else if (is_payload)
        begin
            results.count  = item_eof ? 2'd2 : 2'd1;
            results.first  = pay_res;
            results.second = vd_res;
        end
        else
        begin
            results.count  = {1'b0, item_eof};
            results.first  = vd_res;
            results.second = vd_res;
        end
    end

    assign pos_next = item_eof ? '0 : count;

    always_ff @(posedge clk)
    begin
        if (item_valid && in_header)
        begin
            hdr_reg[wr_idx] <= item_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            throttle_reg <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
            csum_en_reg  <= 1'b1;
        end
        else
        begin
            if (item_valid)
            begin
                pos_reg <= pos_next;
                sum_reg <= item_eof ? 16'd0 : sum_next;
                if (item_eof && apply_flow)
                begin
                    throttle_reg <= throttle_new;
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_FRAME_CAPACITY:  capacity_reg <= cfg_wdata;
                    CFG_CHECKSUM_ENABLE: csum_en_reg  <= cfg_wdata[0];
                    default:             ;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_eof |=> pos_reg == '0 && sum_reg == 16'd0)
        else $error("position or sum not cleared after final byte");
    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_eof && pos_reg != POS_MAX |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("byte position did not advance");
`endif

endmodule

`default_nettype wire

>>> src/tfc_result_fifo.sv
// Result queue taking up to two results a cycle and releasing one when the output is ready.
`timescale 1ns / 1ps
`default_nettype none

module tfc_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tfc_pkg::results_t push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tfc_pkg::result_t       out_item
);
    import tfc_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_inc;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;

    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && out_ready;
    assign room       = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_item   = mem[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign count_next = count_reg + {1'b0, push.count} - {{(FIFO_CNT_W-1){1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the transport frame checker: table-driven frames, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import tfc_pkg::*;

    localparam int HDR_BYTES = HEADER_BYTES_DEF;
    localparam logic [2:0] VD_PREDICT = 3'd7;   // row has no typed verdict
    localparam int LONG_BODY = 131090;          // runs the position counter into saturation
    localparam int RANDOM_BYTES = 1100;
    localparam int FRAMES_PER_SETTING = 8;

    typedef enum logic [1:0] {SUM_GOOD, SUM_BAD, SUM_ZERO} sum_mode_t;

    typedef struct packed {
        logic [7:0]  iface_byte;
        logic [7:0]  flags;
        logic [15:0] len;
        logic [15:0] off;
        logic [7:0]  rsvd0;
        logic [7:0]  rsvd1;
        logic [7:0]  flow_byte;
        logic [7:0]  rsvd2;
        sum_mode_t   sum_mode;
        int          body;      // bytes after the header: payload, then padding
        int          cut;       // nonzero: send only this many bytes
        logic [2:0]  want;
    } frame_spec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_CAPACITY;
    logic [15:0]          cfg_data = 16'h0000;

    // predictor state
    logic [7:0]  hdr_copy [HDR_BYTES] = '{default: 8'h00};
    logic [16:0] rx_pos = '0;
    logic [15:0] rx_sum = '0;
    logic        throttle_state = 1'b0;
    logic [15:0] capacity_setting = CAPACITY_RESET;
    logic        checksum_on = 1'b1;

    result_t     pending_results [$];
    int          mismatch_count = 0;
    int          sent_bytes = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;

    frame_spec_t directed_frames [21] = '{
        // iface  flags  len       off       r8     r9     flow   r11    checksum body cut want
        '{8'hff, 8'hff, 16'd0,    16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 0, 1,
          VD_SHORT},
        '{8'h00, 8'h00, 16'd0,    16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 0, 11,
          VD_SHORT},
        '{8'h00, 8'h00, 16'd0,    16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 0, 0,
          VD_EMPTY},
        '{8'h03, 8'h5a, 16'd0,    16'd12,   8'h00, 8'h00, 8'h01, 8'h00, SUM_GOOD, 0, 0,
          VD_FLOW_OK},
        '{8'hf8, 8'h00, 16'd0,    16'd0,    8'h00, 8'h00, 8'h02, 8'h00, SUM_ZERO, 0, 0,
          VD_FLOW_OK},
        '{8'hf8, 8'h00, 16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00, SUM_ZERO, 2, 0,
          VD_FLOW_OK},
        '{8'h78, 8'h00, 16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00, SUM_ZERO, 0, 0,
          VD_BAD_SENT},
        '{8'hf8, 8'h01, 16'd0,    16'd0,    8'h00, 8'h00, 8'h01, 8'h00, SUM_ZERO, 0, 0,
          VD_BAD_SENT},
        '{8'hf8, 8'h00, 16'd0,    16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_ZERO, 0, 0,
          VD_BAD_SENT},
        '{8'hf8, 8'h00, 16'd0,    16'd0,    8'h00, 8'h00, 8'h01, 8'h00, SUM_GOOD, 0, 0,
          VD_BAD_SENT},
        '{8'hf8, 8'h00, 16'd0,    16'd0,    8'h00, 8'h80, 8'h00, 8'h00, SUM_ZERO, 0, 0,
          VD_BAD_SENT},
        '{8'hf8, 8'h00, 16'd0,    16'd0,    8'h00, 8'h00, 8'hfd, 8'h00, SUM_ZERO, 0, 0,
          VD_BAD_SENT},
        '{8'h01, 8'h10, 16'd2,    16'd13,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 2, 0,
          VD_BAD_HDR},
        '{8'h05, 8'h20, 16'd1589, 16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 3, 0,
          VD_BAD_HDR},
        '{8'h06, 8'h30, 16'd10,   16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 4, 0,
          VD_BAD_HDR},
        '{8'h07, 8'h40, 16'hffff, 16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 5, 0,
          VD_BAD_HDR},
        '{8'h09, 8'h50, 16'd1,    16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, SUM_GOOD, 1, 0,
          VD_BAD_HDR},
        '{8'h0a, 8'h60, 16'd4,    16'd12,   8'h00, 8'h00, 8'h00, 8'h00, SUM_BAD,  4, 0,
          VD_BAD_CSUM},
        '{8'hff, 8'hff, 16'd4,    16'd12,   8'hff, 8'hff, 8'hff, 8'hff, SUM_GOOD, 4, 0,
          VD_DELIVERED},
        '{8'h02, 8'h00, 16'd3,    16'd12,   8'h11, 8'h22, 8'h01, 8'h33, SUM_GOOD, 6, 0,
          VD_PREDICT},
        '{8'h04, 8'h0f, 16'd5,    16'd12,   8'h00, 8'h00, 8'h02, 8'h00, SUM_GOOD, LONG_BODY, 0,
          VD_DELIVERED}
    };

    transport_frame_checker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? int'($urandom_range(0, 16)) : 0;
    endfunction

    // Work out the results one accepted byte causes and queue them in order.
    task automatic predict_results(input logic [7:0] rx, input logic eof);
        logic [16:0] pos;
        logic [16:0] count;
        logic [15:0] len;
        logic [15:0] off;
        logic [15:0] limit;
        logic [1:0]  flow;
        logic        apply;
        result_t     r;
        pos = rx_pos;
        if (pos < 17'(HDR_BYTES))
        begin
            hdr_copy[pos] = rx;
            if (pos != HDR_SUM_LO && pos != HDR_SUM_HI)
                rx_sum += 16'(rx);
        end
        else if (int'(pos) < HDR_BYTES + int'({hdr_copy[HDR_LEN_HI], hdr_copy[HDR_LEN_LO]}))
        begin
            rx_sum += 16'(rx);
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload = rx;
            r.channel = 4'(hdr_copy[HDR_IFACE] & NIBBLE_MASK);
            r.flags = hdr_copy[HDR_FLAGS];
            r.verdict = VD_DELIVERED;
            r.throttled = throttle_state;
            r.last = !eof;
            pending_results.push_back(r);
        end
        count = (pos < POS_MAX) ? pos + 17'd1 : POS_MAX;
        if (!eof)
            rx_pos = count;
        else
        begin
            r = '0;
            r.kind = KIND_VERDICT;
            r.last = 1'b1;
            apply = 1'b0;
            flow = 2'(hdr_copy[HDR_FLOW] & FLOW_MASK);
            if (count < 17'(HDR_BYTES))
                r.verdict = VD_SHORT;
            else
            begin
                r.channel = 4'(hdr_copy[HDR_IFACE] & NIBBLE_MASK);
                r.flags = hdr_copy[HDR_FLAGS];
                len = {hdr_copy[HDR_LEN_HI], hdr_copy[HDR_LEN_LO]};
                off = {hdr_copy[HDR_OFF_HI], hdr_copy[HDR_OFF_LO]};
                limit = (capacity_setting < 16'(HDR_BYTES)) ? 16'd0
                                                           : capacity_setting - 16'(HDR_BYTES);
                if (len == 16'd0 && r.channel == IF_SENTINEL)
                begin
                    if (hdr_copy[HDR_IFACE] != (SENTINEL_TOP | {4'h0, IF_SENTINEL}) ||
                        hdr_copy[HDR_FLAGS] != 8'h00 || off != 16'd0 ||
                        {hdr_copy[HDR_SUM_HI], hdr_copy[HDR_SUM_LO]} != 16'd0 ||
                        hdr_copy[HDR_RSVD0] != 8'h00 || hdr_copy[HDR_RSVD1] != 8'h00 ||
                        (hdr_copy[HDR_FLOW] & FLOW_RSVD_MASK) != 8'h00 ||
                        hdr_copy[HDR_RSVD2] != 8'h00)
                        r.verdict = VD_BAD_SENT;
                    else
                    begin
                        apply = 1'b1;
                        r.verdict = VD_FLOW_OK;
                    end
                end
                else if (off != 16'(HDR_BYTES) || len > limit ||
                         int'(off) + int'(len) > int'(count))
                    r.verdict = VD_BAD_HDR;
                else if (checksum_on && rx_sum != {hdr_copy[HDR_SUM_HI], hdr_copy[HDR_SUM_LO]})
                    r.verdict = VD_BAD_CSUM;
                else
                begin
                    apply = 1'b1;
                    if (len != 16'd0)
                        r.verdict = VD_DELIVERED;
                    else if (flow == FLOW_SET || flow == FLOW_CLEAR)
                        r.verdict = VD_FLOW_OK;
                    else
                        r.verdict = VD_EMPTY;
                end
            end
            if (apply)
            begin
                r.released = throttle_state && flow == FLOW_CLEAR;
                if (flow == FLOW_SET)
                    throttle_state = 1'b1;
                else if (flow == FLOW_CLEAR)
                    throttle_state = 1'b0;
            end
            r.throttled = throttle_state;
            pending_results.push_back(r);
            rx_pos = '0;
            rx_sum = '0;
        end
    endtask

    task automatic send_frame(input frame_spec_t f);
        logic [7:0]  bytes [$];
        logic [15:0] sum;
        int          total;
        int          gap;
        bytes = '{f.iface_byte, f.flags, f.len[7:0], f.len[15:8], f.off[7:0], f.off[15:8],
                  8'h00, 8'h00, f.rsvd0, f.rsvd1, f.flow_byte, f.rsvd2};
        repeat (f.body) bytes.push_back(8'($urandom));
        sum = '0;
        for (int i = 0; i < bytes.size() && i < HDR_BYTES + int'(f.len); i++)
            if (i != HDR_SUM_LO && i != HDR_SUM_HI)
                sum += 16'(bytes[i]);
        if (f.sum_mode == SUM_BAD)
            sum ^= 16'(1) << $urandom_range(0, 15);
        else if (f.sum_mode == SUM_ZERO)
            sum = '0;
        bytes[HDR_SUM_LO] = sum[7:0];
        bytes[HDR_SUM_HI] = sum[15:8];
        total = (f.cut > 0) ? f.cut : bytes.size();
        for (int i = 0; i < total; i++)
        begin
            gap = draw_gap(src_idle_on);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= bytes[i];
            s_axis_tlast  <= (i == total - 1);
            do @(posedge clk); while (!s_axis_tready);
            sent_bytes++;
            predict_results(bytes[i], i == total - 1);
        end
        // the verdict is the newest entry and cannot have left the block yet
        if (f.want != VD_PREDICT)
            pending_results[$].verdict = f.want;
    endtask

    task automatic drain_results(input int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write both registers back to back, holding the request high between them.
    task automatic write_config(input logic [15:0] capacity, input logic csum_on);
        drain_results(4);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_CAPACITY;
        cfg_data  <= capacity;
        do @(posedge clk); while (!cfg_ready);
        capacity_setting = capacity;
        cfg_index <= CFG_CHECKSUM_ENABLE;
        cfg_data  <= {15'd0, csum_on};
        do @(posedge clk); while (!cfg_ready);
        checksum_on = csum_on;
        cfg_valid <= 1'b0;
    endtask

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected kind %0d byte %02h ch %0d flags %02h vd %0d thr %0d",
                     $time, what, want.kind, want.payload, want.channel, want.flags,
                     want.verdict, want.throttled);
            $display("    expected rel %0d last %0d, got kind %0d byte %02h ch %0d flags %02h",
                     want.released, want.last, got.kind, got.payload, got.channel, got.flags);
            $display("    got vd %0d thr %0d rel %0d last %0d",
                     got.verdict, got.throttled, got.released, got.last);
        end
    endtask

    initial
    begin : result_sink
        result_t got;
        result_t want;
        int      stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_idle_on = !sink_idle_on;
            stall = draw_gap(sink_idle_on);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.kind      = m_axis_tuser;
            got.payload   = m_axis_tdata[7:0];
            got.channel   = m_axis_tdata[11:8];
            got.flags     = m_axis_tdata[19:12];
            got.verdict   = m_axis_tdata[22:20];
            got.throttled = m_axis_tdata[23];
            got.released  = m_axis_tdata[24];
            got.last      = m_axis_tlast;
            if (pending_results.size() == 0)
                log_mismatch("result with none pending", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin : stimulus
        frame_spec_t f;
        logic [15:0] limit;
        int          frames;
        int          pick;
        int          max_len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_frames[i])
        begin
            src_idle_on = directed_frames[i].body < 1000;
            send_frame(directed_frames[i]);
        end

        frames = 0;
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            if (frames % FRAMES_PER_SETTING == 0)
            begin
                case ((frames / FRAMES_PER_SETTING) % 6)
                    0: write_config(16'd12, 1'b1);
                    1: write_config(16'hffff, 1'b0);
                    2: write_config(16'($urandom_range(13, 64)), 1'b1);
                    3: write_config(16'hffff, 1'b1);
                    4: write_config(16'($urandom_range(12, 40)), 1'b0);
                    default: write_config(CAPACITY_RESET, 1'b1);
                endcase
            end
            frames++;
            src_idle_on = $urandom_range(0, 3) != 0;
            // capacity never goes below the header size here
            limit = capacity_setting - 16'(HDR_BYTES);
            max_len = (limit < 16'd24) ? int'(limit) : 24;

            // start from a well-formed data frame with random content
            f = '0;
            f.iface_byte = 8'($urandom);
            f.flags      = 8'($urandom);
            f.len        = 16'($urandom_range(0, max_len));
            f.off        = 16'(HDR_BYTES);
            f.rsvd0      = 8'($urandom);
            f.rsvd1      = 8'($urandom);
            f.flow_byte  = 8'($urandom);
            f.rsvd2      = 8'($urandom);
            f.sum_mode   = SUM_GOOD;
            f.body       = int'(f.len) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            f.cut        = 0;
            f.want       = VD_PREDICT;

            pick = $urandom_range(0, 99);
            if (pick < 50)
                ;
            else if (pick < 60)
            begin
                // empty frame: the flow code decides, unless the interface byte marks a sentinel
                f.len  = 16'd0;
                f.body = $urandom_range(0, 2);
            end
            else if (pick < 72)
            begin
                f.iface_byte = SENTINEL_TOP | {4'h0, IF_SENTINEL};
                f.flags      = 8'h00;
                f.len        = 16'd0;
                f.off        = 16'd0;
                f.rsvd0      = 8'h00;
                f.rsvd1      = 8'h00;
                f.flow_byte  = 8'($urandom_range(0, 3));
                f.rsvd2      = 8'h00;
                f.sum_mode   = SUM_ZERO;
                f.body       = $urandom_range(0, 2);
                if ($urandom_range(0, 1) == 1)
                begin
                    // break one rule of the idle sentinel, and at times rsvd1 as well
                    case ($urandom_range(0, 6))
                        0: f.iface_byte[7:4] = 4'($urandom_range(0, 14));
                        1: f.flags = 8'($urandom_range(1, 255));
                        2: f.off = 16'($urandom_range(1, 65535));
                        3: f.sum_mode = SUM_GOOD;
                        4: f.rsvd0 = 8'($urandom_range(1, 255));
                        5: f.rsvd2 = 8'($urandom_range(1, 255));
                        default: f.flow_byte[7:2] = 6'($urandom_range(1, 63));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        f.rsvd1 = 8'($urandom_range(1, 255));
                end
            end
            else if (pick < 80)
                f.cut = $urandom_range(1, HDR_BYTES - 1);
            else if (pick < 88)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        f.off = 16'($urandom);
                        if (f.off == 16'(HDR_BYTES))
                            f.off = 16'(HDR_BYTES + 1);
                    end
                    1:
                    begin
                        f.len  = limit + 16'($urandom_range(1, 4));
                        f.body = $urandom_range(0, 4);
                    end
                    default:
                    begin
                        // truncated payload
                        if (f.len == 16'd0)
                            f.len = 16'd1;
                        f.body = $urandom_range(0, int'(f.len) - 1);
                    end
                endcase
            end
            else if (pick < 95)
                f.sum_mode = SUM_BAD;
            else
            begin
                // noise header
                f.len      = 16'($urandom);
                f.off      = 16'($urandom);
                f.sum_mode = SUM_BAD;
                f.body     = $urandom_range(0, 20);
            end
            send_frame(f);
        end

        drain_results(8);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #(4_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
